/* hw/rtl/gn3_pkg.sv */
`default_nettype none
package gn3_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW   = 24;
  localparam int unsigned IdxW     = CoordW - FracBits;
  localparam int unsigned GradW    = FracBits + 3;
  localparam int unsigned ValW     = FracBits + 4;
  localparam int unsigned WeightW  = FracBits + 1;
  localparam int unsigned ProdW    = ValW + 1 + WeightW + 1;
  localparam int unsigned OutW     = 16;
  localparam int unsigned InDataW  = 88;

  typedef enum logic {
    MODE_EVAL = 1'b0,
    MODE_LOAD = 1'b1
  } mode_e;

  // Corner gradient: the low four hash bits pick two offsets and their signs.
  function automatic logic signed [GradW-1:0] grad_f(
    input logic [3:0]                  h,
    input logic signed [FracBits:0]    x,
    input logic signed [FracBits:0]    y,
    input logic signed [FracBits:0]    z
  );
    logic signed [GradW-1:0] u;
    logic signed [GradW-1:0] v;
    u = (h < 4'd8) ? GradW'(x) : GradW'(y);
    if (h < 4'd4) begin
      v = GradW'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = GradW'(x);
    end else begin
      v = GradW'(z);
    end
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/gn3_perm_ram.sv */
`default_nettype none
module gn3_perm_ram
  import gn3_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [IdxW-1:0] wdata_i,
  input  wire logic [IdxW-1:0] raddr0_i,
  input  wire logic [IdxW-1:0] raddr1_i,
  output logic      [IdxW-1:0] rdata0_o,
  output logic      [IdxW-1:0] rdata1_o
);

  logic [IdxW-1:0] mem_q [2**IdxW];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gn3_fade.sv */
`default_nettype none
module gn3_fade
  import gn3_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [FracBits-1:0] t_i,
  output logic      [FracBits:0]   fade_o
);

  localparam int unsigned SW = FracBits + 5;

  logic [FracBits-1:0]   t1_q, t2t_q;
  logic [2*FracBits-1:0] tt_q;
  logic [FracBits-1:0]   sq_q;
  logic [SW-1:0]         s2_q, s3_q;
  logic [FracBits-1:0]   cube_q;
  logic [2*FracBits-1:0] tsq_full;
  logic [2*FracBits+2:0] six_tt;
  logic [FracBits+SW-1:0] prod;
  logic [SW-1:0]          f_q;

  assign six_tt   = (2*FracBits+3)'(tt_q) * (2*FracBits+3)'(6);
  assign tsq_full = sq_q * t2t_q;
  assign prod     = (FracBits+SW)'(cube_q) * (FracBits+SW)'(s3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t_i;
      tt_q   <= t_i * t_i;
      t2t_q  <= t1_q;
      sq_q   <= tt_q[2*FracBits-1:FracBits];
      s2_q   <= SW'(10 << FracBits) + SW'(six_tt >> FracBits) - SW'(15) * SW'(t1_q);
      cube_q <= tsq_full[2*FracBits-1:FracBits];
      s3_q   <= s2_q;
      f_q    <= SW'(prod >> FracBits);
    end
  end

  assign fade_o = (f_q > SW'(1 << FracBits)) ? (FracBits+1)'(1 << FracBits)
                                             : f_q[FracBits:0];

endmodule
`default_nettype wire

/* hw/rtl/gradient_noise_3d_core.sv */
`default_nettype none
// Throughput: one word per cycle, evaluate or load; the whole pipeline advances
// together, so a stall at the output holds every stage and nothing is lost.
// Reset clears only the stage valid bits; the permutation copies are undefined
// until loaded. Load words write each table copy as they pass its stage.
module gradient_noise_3d_core
  import gn3_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata: table_index[7:0], table_value[15:8], coord_x[39:16],
  // coord_y[63:40], coord_z[87:64]
  input  wire logic [InDataW-1:0] s_axis_tdata_i,
  // tuser: mode
  input  wire logic               s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // tdata: noise_value[15:0]
  output logic      [OutW-1:0]    m_axis_tdata_o
);

  localparam int unsigned NStg = 11;
  localparam logic signed [ValW:0] OneS = (ValW+1)'(1) << FracBits;

  // Every stage moves when the output register is free or being drained.
  logic en;
  logic [NStg:1] ev_q;
  logic ld1_q, ld2_q;
  assign en              = !ev_q[NStg] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = ev_q[NStg];

  logic [IdxW-1:0]   in_idx, in_val;
  logic [CoordW-1:0] in_x, in_y, in_z;
  logic              in_fire, in_ev, in_ld;
  assign in_idx  = s_axis_tdata_i[7:0];
  assign in_val  = s_axis_tdata_i[15:8];
  assign in_x    = s_axis_tdata_i[39:16];
  assign in_y    = s_axis_tdata_i[63:40];
  assign in_z    = s_axis_tdata_i[87:64];
  assign in_fire = s_axis_tvalid_i && en;
  assign in_ev   = in_fire && (mode_e'(s_axis_tuser_i) == MODE_EVAL);
  assign in_ld   = in_fire && (mode_e'(s_axis_tuser_i) == MODE_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q  <= '0;
      ld1_q <= 1'b0;
      ld2_q <= 1'b0;
    end else if (en) begin
      ev_q  <= {ev_q[NStg-1:1], in_ev};
      ld1_q <= in_ld;
      ld2_q <= ld1_q;
    end
  end

  // Payload carried alongside the table lookups.
  logic [IdxW-1:0]     widx1_q, wval1_q, widx2_q, wval2_q;
  logic [IdxW-1:0]     y1_q, z1_q, z2_q;
  logic [FracBits-1:0] fx1_q, fy1_q, fz1_q, fx2_q, fy2_q, fz2_q, fx3_q, fy3_q, fz3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      widx1_q <= in_idx;
      wval1_q <= in_val;
      widx2_q <= widx1_q;
      wval2_q <= wval1_q;
      y1_q    <= in_y[CoordW-1:FracBits];
      z1_q    <= in_z[CoordW-1:FracBits];
      z2_q    <= z1_q;
      fx1_q   <= in_x[FracBits-1:0];
      fy1_q   <= in_y[FracBits-1:0];
      fz1_q   <= in_z[FracBits-1:0];
      fx2_q   <= fx1_q;
      fy2_q   <= fy1_q;
      fz2_q   <= fz1_q;
      fx3_q   <= fx2_q;
      fy3_q   <= fy2_q;
      fz3_q   <= fz2_q;
    end
  end

  // Hash level one: P[X], P[X+1].
  logic [IdxW-1:0] px_x, ix;
  assign ix = in_x[CoordW-1:FracBits];
  logic [IdxW-1:0] pa_raw, pb_raw;
  gn3_perm_ram u_ram1 (
    .clk_i, .en_i(en), .we_i(in_ld), .waddr_i(in_idx), .wdata_i(in_val),
    .raddr0_i(ix), .raddr1_i(ix + IdxW'(1)),
    .rdata0_o(pa_raw), .rdata1_o(pb_raw)
  );
  assign px_x = pa_raw;

  // Hash level two: A = P[X]+Y, B = P[X+1]+Y.
  logic [IdxW-1:0] ha, hb, ta, ta1, tb, tb1;
  assign ha = px_x + y1_q;
  assign hb = pb_raw + y1_q;
  gn3_perm_ram u_ram2a (
    .clk_i, .en_i(en), .we_i(ld1_q), .waddr_i(widx1_q), .wdata_i(wval1_q),
    .raddr0_i(ha), .raddr1_i(ha + IdxW'(1)), .rdata0_o(ta), .rdata1_o(ta1)
  );
  gn3_perm_ram u_ram2b (
    .clk_i, .en_i(en), .we_i(ld1_q), .waddr_i(widx1_q), .wdata_i(wval1_q),
    .raddr0_i(hb), .raddr1_i(hb + IdxW'(1)), .rdata0_o(tb), .rdata1_o(tb1)
  );

  // Hash level three: the eight corner hashes, order AA, BA, AB, BB.
  logic [IdxW-1:0] corner [4];
  logic [IdxW-1:0] hz0 [4];
  logic [IdxW-1:0] hz1 [4];
  assign corner[0] = ta  + z2_q;
  assign corner[1] = tb  + z2_q;
  assign corner[2] = ta1 + z2_q;
  assign corner[3] = tb1 + z2_q;

  for (genvar c = 0; c < 4; c++) begin : g_ram3
    gn3_perm_ram u_ram3 (
      .clk_i, .en_i(en), .we_i(ld2_q), .waddr_i(widx2_q), .wdata_i(wval2_q),
      .raddr0_i(corner[c]), .raddr1_i(corner[c] + IdxW'(1)),
      .rdata0_o(hz0[c]), .rdata1_o(hz1[c])
    );
  end

  // Fade curves, four stages each; ready in step with the gradients.
  logic [FracBits:0] fu, fv, fw;
  gn3_fade u_fade_x (.clk_i, .en_i(en), .t_i(in_x[FracBits-1:0]), .fade_o(fu));
  gn3_fade u_fade_y (.clk_i, .en_i(en), .t_i(in_y[FracBits-1:0]), .fade_o(fv));
  gn3_fade u_fade_z (.clk_i, .en_i(en), .t_i(in_z[FracBits-1:0]), .fade_o(fw));

  // Corner offsets: the fraction, or the fraction minus one.
  logic signed [FracBits:0] ox0, oy0, oz0, ox1, oy1, oz1;
  assign ox0 = $signed({1'b0, fx3_q});
  assign oy0 = $signed({1'b0, fy3_q});
  assign oz0 = $signed({1'b0, fz3_q});
  assign ox1 = $signed({1'b1, fx3_q});
  assign oy1 = $signed({1'b1, fy3_q});
  assign oz1 = $signed({1'b1, fz3_q});

  logic signed [GradW-1:0] g4_q [8];
  always_ff @(posedge clk_i) begin
    if (en) begin
      g4_q[0] <= grad_f(hz0[0][3:0], ox0, oy0, oz0);
      g4_q[1] <= grad_f(hz0[1][3:0], ox1, oy0, oz0);
      g4_q[2] <= grad_f(hz0[2][3:0], ox0, oy1, oz0);
      g4_q[3] <= grad_f(hz0[3][3:0], ox1, oy1, oz0);
      g4_q[4] <= grad_f(hz1[0][3:0], ox0, oy0, oz1);
      g4_q[5] <= grad_f(hz1[1][3:0], ox1, oy0, oz1);
      g4_q[6] <= grad_f(hz1[2][3:0], ox0, oy1, oz1);
      g4_q[7] <= grad_f(hz1[3][3:0], ox1, oy1, oz1);
    end
  end

  // Blend along x, then y, then z; each blend is a multiply stage then an add stage.
  logic signed [WeightW:0] wu, wv6, wz8;
  logic [FracBits:0] v5_q, v6_q, w5_q, w6_q, w7_q, w8_q;
  logic signed [ProdW-1:0] px5_q [4];
  logic signed [ValW-1:0]  a5_q [4];
  logic signed [ValW-1:0]  l6_q [4];
  logic signed [ProdW-1:0] py7_q [2];
  logic signed [ValW-1:0]  a7_q [2];
  logic signed [ValW-1:0]  m8_q [2];
  logic signed [ProdW-1:0] pz9_q;
  logic signed [ValW-1:0]  a9_q;
  logic signed [ValW-1:0]  res10_q;
  logic [OutW-1:0]         out_q;

  assign wu  = $signed({1'b0, fu});
  assign wv6 = $signed({1'b0, v6_q});
  assign wz8 = $signed({1'b0, w8_q});

  // (res + 1) / 2 in Q0.16, saturated.
  function automatic logic [OutW-1:0] out_map(input logic signed [ValW-1:0] r);
    logic signed [ValW:0] val;
    logic [ValW:0]        half;
    val  = (ValW+1)'(r) + OneS;
    half = $unsigned(val) >> (FracBits - 15);
    if (val <= 0) begin
      return '0;
    end else if (half > (ValW+1)'(16'hFFFF)) begin
      return '1;
    end else begin
      return half[OutW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      v5_q <= fv;
      v6_q <= v5_q;
      w5_q <= fw;
      w6_q <= w5_q;
      w7_q <= w6_q;
      w8_q <= w7_q;
      for (int k = 0; k < 4; k++) begin
        a5_q[k]  <= ValW'(g4_q[2*k]);
        px5_q[k] <= ProdW'(wu) * (ProdW'(g4_q[2*k+1]) - ProdW'(g4_q[2*k]));
        l6_q[k]  <= a5_q[k] + ValW'(px5_q[k] >>> FracBits);
      end
      for (int k = 0; k < 2; k++) begin
        a7_q[k]  <= l6_q[2*k];
        py7_q[k] <= ProdW'(wv6) * (ProdW'(l6_q[2*k+1]) - ProdW'(l6_q[2*k]));
        m8_q[k]  <= a7_q[k] + ValW'(py7_q[k] >>> FracBits);
      end
      a9_q    <= m8_q[0];
      pz9_q   <= ProdW'(wz8) * (ProdW'(m8_q[1]) - ProdW'(m8_q[0]));
      res10_q <= a9_q + ValW'(pz9_q >>> FracBits);
      out_q   <= out_map(res10_q);
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule
`default_nettype wire

/* tb/tb_gradient_noise_3d_core.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_gradient_noise_3d_core
  import gn3_pkg::*;
();

  typedef struct packed {
    logic [23:0] z;
    logic [23:0] y;
    logic [23:0] x;
    logic [7:0]  val;
    logic [7:0]  idx;
  } noise_word_t;

  typedef struct {
    mode_e       mode;
    noise_word_t data;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic [InDataW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tready_i = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OutW-1:0] m_axis_tdata_o;

  gradient_noise_3d_core uut (.*);

  always #4 clk_i = ~clk_i;

  stim_t       pending_q[$];
  logic [15:0] noise_expected_q[$];
  logic [7:0]  perm_shadow[256];
  int          mismatch_cnt = 0;
  bit          quiet_mode = 1'b0;
  bit          hold_sender = 1'b0;
  bit          in_taken = 1'b0;

  function automatic longint floor_shr(longint v);
    return v >>> FracBits;
  endfunction

  function automatic longint fade_of(longint t);
    longint t2, t3, s, f;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    s = 10 * 65536 + ((6 * t * t) >> 16) - 15 * t;
    f = (t3 * s) >> 16;
    return (f > 65536) ? 65536 : f;
  endfunction

  function automatic longint mix(longint w, longint a, longint b);
    return a + floor_shr(w * (b - a));
  endfunction

  function automatic longint corner_grad(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] perm(longint i);
    return perm_shadow[i[7:0]];
  endfunction

  function automatic logic [15:0] noise_at(noise_word_t d);
    longint xi, yi, zi, x, y, z, u, v, w, a, b, aa, ab, ba, bb, res, val;
    xi = d.x[23:16]; yi = d.y[23:16]; zi = d.z[23:16];
    x = d.x[15:0]; y = d.y[15:0]; z = d.z[15:0];
    u = fade_of(x); v = fade_of(y); w = fade_of(z);
    a = perm(xi) + yi;      b = perm(xi + 1) + yi;
    aa = perm(a) + zi;      ab = perm(a + 1) + zi;
    ba = perm(b) + zi;      bb = perm(b + 1) + zi;
    res = mix(w,
      mix(v, mix(u, corner_grad(perm(aa), x, y, z), corner_grad(perm(ba), x - 65536, y, z)),
             mix(u, corner_grad(perm(ab), x, y - 65536, z),
                    corner_grad(perm(bb), x - 65536, y - 65536, z))),
      mix(v, mix(u, corner_grad(perm(aa + 1), x, y, z - 65536),
                    corner_grad(perm(ba + 1), x - 65536, y, z - 65536)),
             mix(u, corner_grad(perm(ab + 1), x, y - 65536, z - 65536),
                    corner_grad(perm(bb + 1), x - 65536, y - 65536, z - 65536))));
    val = res + 65536;
    if (val <= 0) return 16'd0;
    val = val >> 1;
    return (val > 65535) ? 16'hFFFF : val[15:0];
  endfunction

  task automatic push_load(logic [7:0] idx, logic [7:0] val);
    stim_t s;
    s.mode = MODE_LOAD;
    s.data = '0;
    s.data.idx = idx;
    s.data.val = val;
    s.data.x = 24'($urandom);
    pending_q.push_back(s);
  endtask

  task automatic push_eval(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    stim_t s;
    s.mode = MODE_EVAL;
    s.data.idx = 8'($urandom);
    s.data.val = 8'($urandom);
    s.data.x = x; s.data.y = y; s.data.z = z;
    pending_q.push_back(s);
  endtask

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 3));
      1: return 24'hFFFFFF - 24'($urandom_range(0, 3));
      2: return {8'($urandom_range(0, 255)), 16'h0000};
      3: return {8'($urandom_range(0, 255)), 16'hFFFF};
      default: return 24'($urandom);
    endcase
  endfunction

  // A word is taken when the previous rising edge accepted it.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (pending_q.size() > 0 && !hold_sender &&
            (quiet_mode || $urandom_range(0, 99) >= 22)) begin
          stim_t s;
          s = pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= s.mode;
          s_axis_tdata_i  <= s.data;
        end else begin
          s_axis_tvalid_i <= 1'b0;
          s_axis_tdata_i  <= InDataW'({$urandom, $urandom, $urandom});
        end
      end
      m_axis_tready_i <= quiet_mode || ($urandom_range(0, 99) >= 22);
    end
  end

  // Prediction at acceptance keeps table loads and evaluations in order.
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_taken) begin
      if (s_axis_tuser_i == MODE_LOAD) begin
        perm_shadow[s_axis_tdata_i[7:0]] = s_axis_tdata_i[15:8];
      end else begin
        noise_expected_q.push_back(noise_at(noise_word_t'(s_axis_tdata_i)));
      end
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (noise_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result word %h", m_axis_tdata_o);
      end else begin
        logic [15:0] exp_v;
        exp_v = noise_expected_q.pop_front();
        if (exp_v !== m_axis_tdata_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("noise_value mismatch: expected %h actual %h", exp_v, m_axis_tdata_o);
        end
      end
    end
  end

  initial begin
    int n;
    // Fill the whole table first so no evaluation reads an unwritten entry.
    for (int i = 0; i < 256; i++) push_load(i[7:0], 8'((i * 151 + 7) & 255));
    push_load(8'hFF, 8'hFF);
    push_load(8'h00, 8'h00);
    push_eval(24'h000000, 24'h000000, 24'h000000);
    push_eval(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    push_eval(24'h008000, 24'h008000, 24'h008000);
    push_eval(24'hFF0000, 24'h00FFFF, 24'h7F8000);
    push_eval(24'h00FFFF, 24'hFFFFFF, 24'h000000);
    for (int i = 0; i < 10; i++) push_eval(24'($urandom), 24'($urandom), 24'($urandom));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    // Drain completely once before reloading and going on.
    hold_sender = 1'b1;
    wait (noise_expected_q.size() == 0 && !s_axis_tvalid_i);
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    n = 0;
    while (n < 480) begin
      if (n == 150) quiet_mode = 1'b1;
      if (n == 300) quiet_mode = 1'b0;
      if ($urandom_range(0, 9) < 2) push_load(8'($urandom), 8'($urandom));
      else push_eval(rnd_coord(), rnd_coord(), rnd_coord());
      n++;
      if (pending_q.size() > 40) wait (pending_q.size() < 10);
    end
    wait (pending_q.size() == 0);
    wait (noise_expected_q.size() == 0);
    repeat (30) @(posedge clk_i);
    if (mismatch_cnt == 0 && noise_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/gn3_pkg.sv
hw/rtl/gn3_perm_ram.sv
hw/rtl/gn3_fade.sv
hw/rtl/gradient_noise_3d_core.sv
tb/tb_gradient_noise_3d_core.sv
